### hw/rtl/pid_pkg.sv
// Shared types and constants for the pulse interval demodulator.
`timescale 1ns / 1ps

package pid_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int IntervalWidth = 16;
  localparam int ByteWidth = 8;
  localparam int BitCountWidth = 3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [COUNT_WIDTH-2:0] thresh_t;
  typedef logic [BitCountWidth-1:0] bit_count_t;

  localparam bit_count_t LastBit = bit_count_t'(7);

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_ARM  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                     opcode;
    logic [IntervalWidth-1:0] interval;
  } pid_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 end_of_message;
  } pid_result_t;

endpackage

### hw/rtl/pid_in_reg.sv
// Input request register in front of the decode stage.
`timescale 1ns / 1ps

module pid_in_reg
  import pid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  pid_item_t in_item,
  input  logic      advance,
  output logic      in_stall,
  output logic      item_valid,
  output pid_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  pid_item_t item_r;

  assign in_stall   = valid_r && !advance;
  assign valid_nxt  = in_stall ? valid_r : in_valid;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

### hw/rtl/pid_core.sv
// Decode state and single-pass edge judging logic.
`timescale 1ns / 1ps

module pid_core
  import pid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  pid_item_t   item,
  input  logic        advance,
  output logic        res_valid,
  output pid_result_t res
);

  logic                 expect_rising_r, expect_rising_nxt;
  logic                 calibrated_r, calibrated_nxt;
  logic                 finished_r, finished_nxt;
  count_t               cal_length_r, cal_length_nxt;
  thresh_t              bit_threshold_r, bit_threshold_nxt;
  logic [ByteWidth-1:0] shift_byte_r, shift_byte_nxt;
  bit_count_t           bit_count_r, bit_count_nxt;
  count_t               count;
  logic                 is_one;

  assign count  = count_t'(item.interval);
  assign is_one = count < {1'b0, bit_threshold_r};

  always_comb begin
    expect_rising_nxt = expect_rising_r;
    calibrated_nxt    = calibrated_r;
    finished_nxt      = finished_r;
    cal_length_nxt    = cal_length_r;
    bit_threshold_nxt = bit_threshold_r;
    shift_byte_nxt    = shift_byte_r;
    bit_count_nxt     = bit_count_r;
    res_valid         = 1'b0;
    res               = '0;
    if (item.opcode == OP_ARM) begin
      expect_rising_nxt = 1'b0;
      calibrated_nxt    = 1'b0;
      finished_nxt      = 1'b0;
      cal_length_nxt    = '0;
      bit_threshold_nxt = '0;
      shift_byte_nxt    = '0;
      bit_count_nxt     = '0;
    end else if (!finished_r) begin
      expect_rising_nxt = !expect_rising_r;
      if (expect_rising_r) begin
        if (!calibrated_r) begin
          cal_length_nxt    = count;
          bit_threshold_nxt = thresh_t'(count >> 1);
          calibrated_nxt    = 1'b1;
        end else if (count > cal_length_r) begin
          // stop interval
          finished_nxt       = 1'b1;
          shift_byte_nxt     = '0;
          bit_count_nxt      = '0;
          res_valid          = 1'b1;
          res.end_of_message = 1'b1;
        end else begin
          shift_byte_nxt = {shift_byte_r[ByteWidth-2:0], is_one};
          if (bit_count_r == LastBit) begin
            res_valid     = 1'b1;
            res.data_byte = shift_byte_nxt;
            bit_count_nxt = '0;
          end else begin
            bit_count_nxt = bit_count_r + bit_count_t'(1);
          end
        end
      end
    end
    // an empty input register carries no request
    res_valid = res_valid && item_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_rising_r <= 1'b0;
      calibrated_r    <= 1'b0;
      finished_r      <= 1'b0;
      cal_length_r    <= '0;
      bit_threshold_r <= '0;
      shift_byte_r    <= '0;
      bit_count_r     <= '0;
    end else if (item_valid && advance) begin
      expect_rising_r <= expect_rising_nxt;
      calibrated_r    <= calibrated_nxt;
      finished_r      <= finished_nxt;
      cal_length_r    <= cal_length_nxt;
      bit_threshold_r <= bit_threshold_nxt;
      shift_byte_r    <= shift_byte_nxt;
      bit_count_r     <= bit_count_nxt;
    end
  end

endmodule

### hw/rtl/pid_out_reg.sv
// Result register on the output channel.
`timescale 1ns / 1ps

module pid_out_reg
  import pid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  pid_result_t res,
  input  logic        out_stall,
  output logic        advance,
  output logic        out_valid,
  output pid_result_t out_res
);

  logic        valid_r;
  logic        valid_nxt;
  pid_result_t res_r;

  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? res_valid : valid_r;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### hw/rtl/pulse_interval_demodulator.sv
// Top level of the pulse interval demodulator.
// An accepted request passes through the input register, the decode logic and then the result register.
// Throughput: one request per cycle; in_stall rises only while the result
// register holds a stalled result and the input register is occupied.
// Reset (synchronous, rst_n low) empties both registers and returns the
// decoder to the armed state: falling edge expected, not calibrated.
`timescale 1ns / 1ps

module pulse_interval_demodulator
  import pid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IntervalWidth-1:0] in_interval,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ByteWidth-1:0]     out_data_byte,
  output logic                     out_end_of_message
);

  pid_item_t   in_item;
  pid_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        res_valid;
  pid_result_t res;
  pid_result_t out_res;

  assign in_item.opcode   = in_opcode;
  assign in_item.interval = in_interval;

  pid_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  pid_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  pid_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_data_byte      = out_res.data_byte;
  assign out_end_of_message = out_res.end_of_message;

`ifndef SYNTH
  a_eom_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_message |-> out_data_byte == '0)
    else $error("end of message with nonzero byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && item_valid)
    else $error("input stalled while pipeline can move");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !item_valid)
    else $error("registers not empty after reset");
`endif

endmodule

### sim/pulse_interval_demodulator_test.sv
// Self-checking testbench for the pulse interval demodulator: random and directed edge streams.
`timescale 1ns / 1ps

module pulse_interval_demodulator_test;
  import pid_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int ResetCycles = 8;
  localparam int Latency = 2;
  localparam int HoldCycles = 400;
  localparam int TimeoutCycles = 200000;
  localparam int ReportLimit = 10;

  class demod_scoreboard;
    logic                 expect_rising;
    logic                 calibrated;
    logic                 finished;
    count_t               cal_length;
    thresh_t              bit_threshold;
    logic [ByteWidth-1:0] shift_byte;
    bit_count_t           bit_count;
    pid_result_t          expected_q[$];
    int                   failures;
    int                   requests;
    int                   bytes_seen;
    int                   stops_seen;

    function new();
      clear_state();
      failures = 0;
      requests = 0;
      bytes_seen = 0;
      stops_seen = 0;
    endfunction

    function void clear_state();
      expect_rising = 1'b0;
      calibrated = 1'b0;
      finished = 1'b0;
      cal_length = '0;
      bit_threshold = '0;
      shift_byte = '0;
      bit_count = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic opcode, logic [IntervalWidth-1:0] interval);
      count_t      count;
      logic        rising;
      pid_result_t res;
      count = count_t'(interval);
      requests++;
      if (opcode == OP_ARM) begin
        clear_state();
        return;
      end
      if (finished) return;
      rising = expect_rising;
      expect_rising = !expect_rising;
      if (!rising) return;
      if (!calibrated) begin
        cal_length = count;
        bit_threshold = thresh_t'(count >> 1);
        calibrated = 1'b1;
        return;
      end
      if (count > cal_length) begin
        finished = 1'b1;
        shift_byte = '0;
        bit_count = '0;
        res.data_byte = '0;
        res.end_of_message = 1'b1;
        expected_q.push_back(res);
        return;
      end
      shift_byte = {shift_byte[ByteWidth-2:0], (count < bit_threshold)};
      if (bit_count == LastBit) begin
        res.data_byte = shift_byte;
        res.end_of_message = 1'b0;
        expected_q.push_back(res);
        bit_count = '0;
      end else begin
        bit_count = bit_count + 1'b1;
      end
    endfunction

    function void check_result(logic [ByteWidth-1:0] data_byte, logic end_of_message);
      pid_result_t exp_res;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected result: data_byte=%02h end_of_message=%b",
                   data_byte, end_of_message);
        return;
      end
      exp_res = expected_q.pop_front();
      if (end_of_message) stops_seen++;
      else bytes_seen++;
      if (data_byte !== exp_res.data_byte || end_of_message !== exp_res.end_of_message) begin
        failures++;
        if (failures <= ReportLimit)
          $display("mismatch: data_byte exp %02h got %02h, end_of_message exp %b got %b",
                   exp_res.data_byte, data_byte, exp_res.end_of_message, end_of_message);
      end
    endfunction

    function void flush_leftover();
      if (expected_q.size() != 0) begin
        failures += expected_q.size();
        $display("%0d expected results never arrived", expected_q.size());
        expected_q.delete();
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_opcode;
  logic [IntervalWidth-1:0] in_interval;
  logic                     out_valid;
  logic                     out_stall;
  logic [ByteWidth-1:0]     out_data_byte;
  logic                     out_end_of_message;

  demod_scoreboard sb = new();
  pid_item_t       stim_q[$];
  pid_item_t       next_req;
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  bit              hold_start = 1'b0;
  bit              hold_taken = 1'b0;
  int              hold_left = 0;
  int              phases_run = 0;

  pulse_interval_demodulator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_interval       (in_interval),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_end_of_message(out_end_of_message)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // request side: note accepted requests, then offer the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_opcode, in_interval);
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = stim_q.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_req.opcode;
          in_interval <= next_req.interval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data_byte, out_end_of_message);
      if (hold_start && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void push_req(logic opcode, logic [IntervalWidth-1:0] interval);
    pid_item_t req;
    req.opcode = opcode;
    req.interval = interval;
    stim_q.push_back(req);
  endfunction

  // arm, calibration, bits, stop; sometimes without arm or stop
  function automatic int add_message();
    int cal;
    int thr;
    int n_bits;
    int pushed;
    int i;
    pushed = 0;
    cal = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(4, 3000);
    thr = cal / 2;
    n_bits = ($urandom_range(1) == 0) ? 8 * $urandom_range(1, 3) : $urandom_range(0, 20);
    if ($urandom_range(99) < 90) begin
      push_req(OP_ARM, IntervalWidth'($urandom));
      pushed++;
    end
    push_req(OP_EDGE, IntervalWidth'($urandom));
    push_req(OP_EDGE, IntervalWidth'(cal));
    pushed += 2;
    for (i = 0; i < n_bits; i++) begin
      push_req(OP_EDGE, IntervalWidth'($urandom));
      if (thr > 0 && $urandom_range(1) == 1)
        push_req(OP_EDGE, IntervalWidth'($urandom_range(0, thr - 1)));
      else
        push_req(OP_EDGE, IntervalWidth'($urandom_range(thr, cal)));
      pushed += 2;
    end
    if (cal < 65535 && $urandom_range(99) < 90) begin
      push_req(OP_EDGE, IntervalWidth'($urandom));
      push_req(OP_EDGE, IntervalWidth'($urandom_range(cal + 1, 65535)));
      pushed += 2;
      // edges after the stop are ignored and not counted
      for (i = $urandom_range(0, 3); i > 0; i--) push_req(OP_EDGE, IntervalWidth'($urandom));
    end
    return pushed;
  endfunction

  function automatic int add_noise();
    int n;
    int i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++)
      push_req(($urandom_range(9) == 0) ? OP_ARM : OP_EDGE, IntervalWidth'($urandom));
    return n;
  endfunction

  function automatic void fill_random(int count);
    int added;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 80) added += add_message();
      else added += add_noise();
    end
  endfunction

  task automatic drain();
    while (stim_q.size() != 0 || in_valid || sb.pending() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int count);
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct = stall;
    fill_random(count);
    phases_run++;
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_EDGE;
    in_interval <= '0;
    out_stall <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // edges before any arm, threshold borders, equal-to-calibration, stop
    push_req(OP_EDGE, 16'h1234);
    push_req(OP_EDGE, 16'd100);
    push_req(OP_EDGE, 16'hFFFF);
    push_req(OP_EDGE, 16'd49);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'd50);
    push_req(OP_EDGE, 16'h8001);
    push_req(OP_EDGE, 16'd100);
    push_req(OP_EDGE, 16'h7FFE);
    push_req(OP_EDGE, 16'd101);
    // ignored after end
    push_req(OP_EDGE, 16'hFFFF);
    push_req(OP_EDGE, 16'hFFFF);
    // maximum calibration: no stop possible
    push_req(OP_ARM, 16'hFFFF);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'hFFFF);
    push_req(OP_EDGE, 16'hAAAA);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'h5555);
    push_req(OP_EDGE, 16'hFFFF);
    // zero calibration
    push_req(OP_ARM, 16'h0000);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'h0000);
    push_req(OP_EDGE, 16'h0001);
    drain();

    run_phase(0, 0, 100);
    run_phase(53, 0, 100);
    run_phase(0, 53, 100);
    run_phase(21, 21, 100);

    // long output hold while requests keep coming
    @(negedge clk);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_start = 1'b1;
    fill_random(100);
    phases_run++;
    drain();

    sb.flush_leftover();
    $display("ran %0d requests over %0d idle/stall phases plus a directed set",
             sb.requests, phases_run);
    $display("received %0d data bytes and %0d end markers", sb.bytes_seen, sb.stops_seen);
    if (sb.failures == 0) begin
      $display("pulse_interval_demodulator_test passed");
    end else begin
      $display("pulse_interval_demodulator_test failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout");
    $display("pulse_interval_demodulator_test failed");
    $finish;
  end

endmodule
